// ===== rtl/bct_pkg.sv =====
package bct_pkg;

    // default image store size
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // reset value of both size registers
    localparam logic [7:0] CFG_RESET_SIZE = 8'd128;

    // grey levels that carry a class
    localparam logic [7:0] GREY_WHITE = 8'd255;
    localparam logic [7:0] GREY_BLACK = 8'd0;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_START = 2'd1,
        FN_NEXT  = 2'd2
    } t_func;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_WHITE = 2'd1,
        CLS_BLACK = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_LAST = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        D_ZERO = 2'd0,
        D_INC  = 2'd1,
        D_DEC  = 2'd2
    } t_delta;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REDUCE,
        S_PROBE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [6:0] point_x;
        logic [6:0] point_y;
        t_status    status;
    } t_result;

    function automatic t_class pixel_class(input logic [7:0] value);
        t_class cls;
        if (value == GREY_WHITE) begin
            cls = CLS_WHITE;
        end else if (value == GREY_BLACK) begin
            cls = CLS_BLACK;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    // column step per direction: w, nw, n, ne, e, se, s, sw
    function automatic t_delta step_dx(input logic [2:0] dir);
        t_delta dd;
        unique case (dir)
            3'd0, 3'd1, 3'd7: dd = D_DEC;
            3'd2, 3'd6:       dd = D_ZERO;
            default:          dd = D_INC;
        endcase
        return dd;
    endfunction

    // row step per direction
    function automatic t_delta step_dy(input logic [2:0] dir);
        t_delta dd;
        unique case (dir)
            3'd1, 3'd2, 3'd3: dd = D_DEC;
            3'd0, 3'd4:       dd = D_ZERO;
            default:          dd = D_INC;
        endcase
        return dd;
    endfunction

endpackage

// ===== rtl/binary_contour_tracer.sv =====
// binary_contour_tracer: outer boundary walk over a stored image of pixel classes
//
// input channel (i_in_valid / o_in_stall) carries one item per handshake:
//   write: i_pixel_x, i_pixel_y, i_pixel_value are classed (255 white, 0 black,
//          other) and stored; no result; the input does not stall
//   start: raster scan for the first white pixel with a black right neighbor;
//          one result, the black pixel or status 2, one pixel read a cycle
//   next:  probes up to seven neighbors, one read a cycle, and moves to the
//          first black one; one result, status 2 with no trace running; the
//          point is folded back first if the image was made smaller during
//          a trace
// output channel (o_out_valid / i_out_stall) gives o_point_x, o_point_y,
//   o_status (0 more follow, 1 last of contour, 2 no point)
// config channel (i_cfg_valid / o_cfg_ready, always ready) writes image width
//   (index 0) or height (index 1); write only while no item is in flight
// one item is worked on at a time; the input stalls until its result is
//   handed to the output register, which then holds it while the receiver
//   stalls, and the next item is taken the cycle after
// reset clears the trace state and sets both sizes to 128; store not cleared
module binary_contour_tracer #(
    parameter int MAX_WIDTH  = bct_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bct_pkg::DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [6:0] i_pixel_x,
    input  logic [6:0] i_pixel_y,
    input  logic [7:0] i_pixel_value,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_point_x,
    output logic [6:0] o_point_y,
    output logic [1:0] o_status,
    // register writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import bct_pkg::*;

    logic [7:0] r_image_width;
    logic [7:0] r_image_height;
    logic       r_out_valid;
    t_result    r_out;

    logic       res_valid;
    logic       res_ready;
    t_result    res;
    logic       cfg_wr;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_RESET_SIZE;
            r_image_height <= CFG_RESET_SIZE;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // tracing engine with the image store
    bct_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_value  (i_pixel_value),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    // output register: free, or emptying this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out.point_x;
    assign o_point_y   = r_out.point_y;
    assign o_status    = r_out.status;

endmodule

// ===== rtl/bct_pixel_mem.sv =====
module bct_pixel_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [1:0]    i_wdata,
    output logic [1:0]    o_rdata
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bct_step.sv =====
module bct_step #(
    parameter int XW = 7,
    parameter int YW = 7
) (
    input  logic [XW-1:0] i_cur_x,
    input  logic [YW-1:0] i_cur_y,
    input  logic [XW:0]   i_width,
    input  logic [YW:0]   i_height,
    input  logic [2:0]    i_dir,
    output logic [XW-1:0] o_x,
    output logic [YW-1:0] o_y
);
    import bct_pkg::*;

    logic [XW:0] x_ext;
    logic [XW:0] x_inc;
    logic [YW:0] y_ext;
    logic [YW:0] y_inc;

    assign x_inc = {1'b0, i_cur_x} + (XW+1)'(1);
    assign y_inc = {1'b0, i_cur_y} + (YW+1)'(1);

    // neighbor with wrap, current point already below the size
    always_comb begin
        unique case (step_dx(i_dir))
            D_DEC:   x_ext = (i_cur_x == '0) ? i_width - (XW+1)'(1)
                                             : {1'b0, i_cur_x} - (XW+1)'(1);
            D_INC:   x_ext = (x_inc == i_width) ? '0 : x_inc;
            default: x_ext = {1'b0, i_cur_x};
        endcase
        unique case (step_dy(i_dir))
            D_DEC:   y_ext = (i_cur_y == '0) ? i_height - (YW+1)'(1)
                                             : {1'b0, i_cur_y} - (YW+1)'(1);
            D_INC:   y_ext = (y_inc == i_height) ? '0 : y_inc;
            default: y_ext = {1'b0, i_cur_y};
        endcase
    end

    assign o_x = x_ext[XW-1:0];
    assign o_y = y_ext[YW-1:0];

endmodule

// ===== rtl/bct_ctrl.sv =====
module bct_ctrl #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_func,
    input  logic [6:0]       i_pixel_x,
    input  logic [6:0]       i_pixel_y,
    input  logic [7:0]       i_pixel_value,
    input  logic [7:0]       i_image_width,
    input  logic [7:0]       i_image_height,
    output logic             o_res_valid,
    output bct_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import bct_pkg::*;

    localparam int EW    = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
    localparam int EH    = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
    localparam int XW    = $clog2(EW);
    localparam int YW    = (EH > 1) ? $clog2(EH) : 1;
    localparam int MCW   = $clog2(EW * EH + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state        r_state, n_state;
    logic [XW-1:0] r_cur_x, n_cur_x;
    logic [YW-1:0] r_cur_y, n_cur_y;
    logic [XW-1:0] r_start_x, n_start_x;
    logic [YW-1:0] r_start_y, n_start_y;
    logic [2:0]    r_dir, n_dir;
    logic [MCW-1:0] r_mc, n_mc;
    logic          r_active, n_active;
    logic          r_iss_done, n_iss_done;
    logic          r_rd_valid, n_rd_valid;
    logic [XW-1:0] r_ix, n_ix;
    logic [YW-1:0] r_iy, n_iy;
    logic [2:0]    r_idx, n_idx;
    logic [XW-1:0] r_rd_x, n_rd_x;
    logic [YW-1:0] r_rd_y, n_rd_y;
    logic [2:0]    r_rd_dir, n_rd_dir;
    logic [1:0]    r_prev_cls, n_prev_cls;
    t_result       r_res, n_res;

    logic [XW:0]    w_eff;
    logic [YW:0]    h_eff;
    logic [MCW-1:0] area;
    logic           in_acc;
    logic           wr_in_range;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic [XW-1:0]  rd_x;
    logic [YW-1:0]  rd_y;
    logic [2:0]     probe_dir;
    logic [XW-1:0]  nb_x;
    logic [YW-1:0]  nb_y;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [1:0]     mem_rdata;
    logic           scan_hit, scan_miss;
    logic           probe_hit, probe_miss;
    logic           scan_row_end, scan_last;
    logic           cur_fits;
    logic           trace_last;

    // sizes in use, clamped
    assign w_eff = (i_image_width == '0) ? (XW+1)'(1)
                 : ((32'(i_image_width) > EW) ? (XW+1)'(EW) : (XW+1)'(i_image_width));
    assign h_eff = (i_image_height == '0) ? (YW+1)'(1)
                 : ((32'(i_image_height) > EH) ? (YW+1)'(EH) : (YW+1)'(i_image_height));
    assign area  = MCW'(32'(w_eff) * 32'(h_eff));

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign wr_in_range = (32'(i_pixel_x) < MAX_WIDTH) && (32'(i_pixel_y) < MAX_HEIGHT);
    assign wr_addr     = AW'(32'(i_pixel_y) * MAX_WIDTH + 32'(i_pixel_x));

    assign probe_dir = r_dir + r_idx;
    assign rd_x      = (r_state == S_SCAN) ? r_ix : nb_x;
    assign rd_y      = (r_state == S_SCAN) ? r_iy : nb_y;
    assign rd_addr   = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));

    bct_step #(
        .XW (XW),
        .YW (YW)
    ) u_step (
        .i_cur_x  (r_cur_x),
        .i_cur_y  (r_cur_y),
        .i_width  (w_eff),
        .i_height (h_eff),
        .i_dir    (probe_dir),
        .o_x      (nb_x),
        .o_y      (nb_y)
    );

    bct_pixel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (pixel_class(i_pixel_value)),
        .o_rdata (mem_rdata)
    );

    // decisions on returning read data
    assign scan_hit   = (r_state == S_SCAN) && r_rd_valid && (r_rd_x != '0)
                     && (r_prev_cls == CLS_WHITE) && (mem_rdata == CLS_BLACK);
    assign scan_miss  = (r_state == S_SCAN) && r_iss_done && !r_rd_valid;
    assign probe_hit  = (r_state == S_PROBE) && r_rd_valid && (mem_rdata == CLS_BLACK);
    assign probe_miss = (r_state == S_PROBE) && r_iss_done && !r_rd_valid;

    assign scan_row_end = ({1'b0, r_ix} == w_eff - (XW+1)'(1));
    assign scan_last    = scan_row_end && ({1'b0, r_iy} == h_eff - (YW+1)'(1));
    assign cur_fits     = ({1'b0, r_cur_x} < w_eff) && ({1'b0, r_cur_y} < h_eff);
    assign trace_last   = ((r_rd_x == r_start_x) && (r_rd_y == r_start_y)) || (r_mc >= area);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        FN_START: n_state = S_SCAN;
                        FN_NEXT:  n_state = r_active ? S_REDUCE : S_EMIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_EMIT;
                end
            end
            S_REDUCE: begin
                if (cur_fits) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_hit || probe_miss) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_res_valid = (r_state == S_EMIT);
        o_res       = r_res;
        mem_we      = in_acc && (i_func == FN_WRITE) && wr_in_range;
        mem_addr    = mem_we ? wr_addr : rd_addr;
    end

    // datapath
    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_start_x  = r_start_x;
        n_start_y  = r_start_y;
        n_dir      = r_dir;
        n_mc       = r_mc;
        n_active   = r_active;
        n_iss_done = r_iss_done;
        n_rd_valid = 1'b0;
        n_ix       = r_ix;
        n_iy       = r_iy;
        n_idx      = r_idx;
        n_rd_x     = r_rd_x;
        n_rd_y     = r_rd_y;
        n_rd_dir   = r_rd_dir;
        n_prev_cls = r_rd_valid ? mem_rdata : r_prev_cls;
        n_res      = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FN_START)) begin
                    n_ix       = '0;
                    n_iy       = '0;
                    n_iss_done = 1'b0;
                end else if (in_acc && (i_func == FN_NEXT)) begin
                    if (r_active) begin
                        n_mc = r_mc + MCW'(1);
                    end else begin
                        n_res = '{point_x: 7'd0, point_y: 7'd0, status: ST_NONE};
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_cur_x   = r_rd_x;
                    n_cur_y   = r_rd_y;
                    n_start_x = r_rd_x;
                    n_start_y = r_rd_y;
                    n_dir     = '0;
                    n_mc      = '0;
                    n_active  = 1'b1;
                    n_res     = '{point_x: 7'(r_rd_x), point_y: 7'(r_rd_y), status: ST_MORE};
                end else if (scan_miss) begin
                    n_active = 1'b0;
                    n_res    = '{point_x: 7'd0, point_y: 7'd0, status: ST_NONE};
                end else if (!r_iss_done) begin
                    // raster order, one pixel read a cycle
                    n_rd_valid = 1'b1;
                    n_rd_x     = r_ix;
                    n_rd_y     = r_iy;
                    n_iss_done = scan_last;
                    if (scan_row_end) begin
                        n_ix = '0;
                        n_iy = r_iy + YW'(1);
                    end else begin
                        n_ix = r_ix + XW'(1);
                    end
                end
            end
            S_REDUCE: begin
                // bring the point back inside a shrunken image
                if ({1'b0, r_cur_x} >= w_eff) begin
                    n_cur_x = XW'({1'b0, r_cur_x} - w_eff);
                end
                if ({1'b0, r_cur_y} >= h_eff) begin
                    n_cur_y = YW'({1'b0, r_cur_y} - h_eff);
                end
                n_idx      = 3'd1;
                n_iss_done = 1'b0;
            end
            S_PROBE: begin
                if (probe_hit) begin
                    n_cur_x  = r_rd_x;
                    n_cur_y  = r_rd_y;
                    n_dir    = {r_rd_dir[2:1] + 2'd3, 1'b0};
                    n_active = !trace_last;
                    n_res    = '{point_x: 7'(r_rd_x), point_y: 7'(r_rd_y),
                                 status: trace_last ? ST_LAST : ST_MORE};
                end else if (probe_miss) begin
                    n_active = 1'b0;
                    n_res    = '{point_x: 7'd0, point_y: 7'd0, status: ST_NONE};
                end else if (!r_iss_done) begin
                    n_rd_valid = 1'b1;
                    n_rd_x     = nb_x;
                    n_rd_y     = nb_y;
                    n_rd_dir   = probe_dir;
                    n_iss_done = (r_idx == 3'd7);
                    n_idx      = r_idx + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_dir      <= '0;
            r_mc       <= '0;
            r_active   <= 1'b0;
            r_iss_done <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
            r_dir      <= n_dir;
            r_mc       <= n_mc;
            r_active   <= n_active;
            r_iss_done <= n_iss_done;
            r_rd_valid <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ix       <= n_ix;
        r_iy       <= n_iy;
        r_idx      <= n_idx;
        r_rd_x     <= n_rd_x;
        r_rd_y     <= n_rd_y;
        r_rd_dir   <= n_rd_dir;
        r_prev_cls <= n_prev_cls;
        r_res      <= n_res;
    end

endmodule

// ===== rtl/bct_checker.sv =====
module bct_assertions (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_func,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_point_x,
    input logic [6:0] o_point_y,
    input logic [1:0] o_status
);
    import bct_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_status))
        else $error("result changed while stalled");

    // no-point results carry a zero point, code 3 never appears
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_NONE || (o_point_x == 7'd0 && o_point_y == 7'd0))
            && o_status != 2'd3)
        else $error("bad status or point on result");

    // writes and unused codes finish at once
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func != FN_START && i_func != FN_NEXT
            |=> !o_in_stall)
        else $error("input stalled after write item");

    // start and next hold the input while they work
    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_func == FN_START || i_func == FN_NEXT)
            |=> o_in_stall)
        else $error("input not stalled during trace item");

endmodule

bind binary_contour_tracer bct_assertions u_bct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_func      (i_func),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_status    (o_status)
);

// ===== dv/bct_checker.sv =====
module bct_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_func,
    input  logic [6:0] i_pixel_x,
    input  logic [6:0] i_pixel_y,
    input  logic [7:0] i_pixel_value,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [6:0] i_point_x,
    input  logic [6:0] i_point_y,
    input  logic [1:0] i_status,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_pending,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bct_pkg::*;

    localparam int IMG_COLS   = DEF_MAX_WIDTH;
    localparam int IMG_ROWS   = DEF_MAX_HEIGHT;
    localparam int REPORT_CAP = 60;

    t_class      pix [IMG_ROWS][IMG_COLS];
    logic [6:0]  here_x, here_y, origin_x, origin_y;
    logic [2:0]  heading;
    int unsigned moves;
    bit          tracing;
    logic [7:0]  width_reg, height_reg;
    t_result     expected_points [$];
    int          waiting;
    int          fails;

    assign o_pending    = waiting;
    assign o_fail_count = fails;

    initial begin
        for (int r = 0; r < IMG_ROWS; r++) begin
            for (int c = 0; c < IMG_COLS; c++) begin
                pix[r][c] = CLS_OTHER;
            end
        end
        waiting = 0;
        fails   = 0;
    end

    function automatic int clamp_size(input logic [7:0] raw, input int limit);
        if (raw == 8'd0) begin
            return 1;
        end
        if (int'(raw) > limit) begin
            return limit;
        end
        return int'(raw);
    endfunction

    // column and row offsets, direction 0 points west and turns clockwise
    function automatic int col_offset(input logic [2:0] dir);
        case (dir)
            3'd0, 3'd1, 3'd7: return -1;
            3'd2, 3'd6:       return 0;
            default:          return 1;
        endcase
    endfunction

    function automatic int row_offset(input logic [2:0] dir);
        case (dir)
            3'd1, 3'd2, 3'd3: return -1;
            3'd0, 3'd4:       return 0;
            default:          return 1;
        endcase
    endfunction

    task automatic advance_tracer(input logic [1:0] func, input logic [6:0] px,
                                  input logic [6:0] py, input logic [7:0] value);
        int         w, h, sx, sy, nx, ny;
        bit         found;
        logic [2:0] dir;
        t_result    pt;
        w = clamp_size(width_reg, IMG_COLS);
        h = clamp_size(height_reg, IMG_ROWS);
        found = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.status  = ST_NONE;
        case (func)
            FN_WRITE: begin
                if (value == GREY_WHITE) begin
                    pix[py][px] = CLS_WHITE;
                end else if (value == GREY_BLACK) begin
                    pix[py][px] = CLS_BLACK;
                end else begin
                    pix[py][px] = CLS_OTHER;
                end
            end
            FN_START: begin
                // raster scan for white followed by black
                for (sy = 0; sy < h && !found; sy++) begin
                    for (sx = 1; sx < w && !found; sx++) begin
                        if (pix[sy][sx-1] == CLS_WHITE && pix[sy][sx] == CLS_BLACK) begin
                            found      = 1'b1;
                            here_x     = sx[6:0];
                            here_y     = sy[6:0];
                            origin_x   = sx[6:0];
                            origin_y   = sy[6:0];
                            heading    = '0;
                            moves      = 0;
                            pt.point_x = sx[6:0];
                            pt.point_y = sy[6:0];
                            pt.status  = ST_MORE;
                        end
                    end
                end
                tracing = found;
                expected_points = {expected_points, pt};
                waiting++;
            end
            FN_NEXT: begin
                if (tracing) begin
                    moves++;
                    for (int i = 1; i < 8 && !found; i++) begin
                        dir = heading + i[2:0];
                        nx  = (int'(here_x) + w + col_offset(dir)) % w;
                        ny  = (int'(here_y) + h + row_offset(dir)) % h;
                        if (pix[ny][nx] == CLS_BLACK) begin
                            found      = 1'b1;
                            here_x     = nx[6:0];
                            here_y     = ny[6:0];
                            heading    = {dir[2:1] + 2'd3, 1'b0};
                            pt.point_x = nx[6:0];
                            pt.point_y = ny[6:0];
                            pt.status  = ST_MORE;
                            if ((here_x == origin_x && here_y == origin_y) ||
                                moves >= w * h) begin
                                pt.status = ST_LAST;
                                tracing   = 1'b0;
                            end
                        end
                    end
                    if (!found) begin
                        tracing = 1'b0;
                    end
                end
                expected_points = {expected_points, pt};
                waiting++;
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [6:0] want,
                                 input logic [6:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP) begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            here_x     = '0;
            here_y     = '0;
            origin_x   = '0;
            origin_y   = '0;
            heading    = '0;
            moves      = 0;
            tracing    = 1'b0;
            width_reg  = CFG_RESET_SIZE;
            height_reg = CFG_RESET_SIZE;
            expected_points.delete();
            waiting    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (waiting == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP) begin
                        $error("result with nothing pending: x %0d y %0d status %0d",
                               i_point_x, i_point_y, i_status);
                    end
                end else begin
                    want = expected_points.pop_front();
                    waiting--;
                    compare_field("point_x", want.point_x, i_point_x);
                    compare_field("point_y", want.point_y, i_point_y);
                    compare_field("status", 7'(want.status), 7'(i_status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data;
                end else begin
                    height_reg = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_tracer(i_func, i_pixel_x, i_pixel_y, i_pixel_value);
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bct_pkg::*;

    localparam int         CLK_HALF      = 5;
    localparam int         RESET_CYCLES  = 9;
    localparam int         ITEM_TARGET   = 1350;
    localparam int         PHASES        = 12;
    // long receiver hold-off, long enough to back up the input
    localparam int         HOLD_CYCLES   = 300;
    // quiet time before a register write, covers a trailing pixel write
    localparam int         SETTLE_CYCLES = 16;
    localparam int         TIMEOUT_NS    = 10_000_000;
    // func code the block has to ignore
    localparam logic [1:0] FN_UNUSED     = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid, in_stall;
    logic [1:0] in_func;
    logic [6:0] in_x, in_y;
    logic [7:0] in_value;
    logic       out_valid, out_stall;
    logic [6:0] pt_x, pt_y;
    logic [1:0] pt_status;
    logic       cfg_valid, cfg_ready;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;
    int         pending, fail_count;

    // stimulus bookkeeping
    bit written [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
    int cur_w, cur_h;
    int burst_left;
    int items_sent, starts_sent, steps_sent;
    bit hold_req;

    always #(CLK_HALF) clk = ~clk;

    binary_contour_tracer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (in_func),
        .i_pixel_x     (in_x),
        .i_pixel_y     (in_y),
        .i_pixel_value (in_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_point_x     (pt_x),
        .o_point_y     (pt_y),
        .o_status      (pt_status),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // watches all three channels, predicts and compares
    bct_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_func        (in_func),
        .i_pixel_x     (in_x),
        .i_pixel_y     (in_y),
        .i_pixel_value (in_value),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_point_x     (pt_x),
        .i_point_y     (pt_y),
        .i_status      (pt_status),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // register value to size in use, zero acts as one and large values saturate
    function automatic int used_size(input logic [7:0] raw);
        if (raw == 8'd0) begin
            return 1;
        end
        return (int'(raw) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(raw);
    endfunction

    // image sizes visited by the random part, extremes and odd shapes mixed
    function automatic void plan_size(input int idx, output logic [7:0] w,
                                      output logic [7:0] h);
        case (idx)
            0:       begin w = 8'd8;   h = 8'd8;   end
            1:       begin w = 8'd0;   h = 8'd0;   end
            2:       begin w = 8'd255; h = 8'd1;   end
            3:       begin w = 8'd2;   h = 8'd128; end
            4:       begin w = 8'd3;   h = 8'd2;   end
            5:       begin w = 8'd1;   h = 8'd255; end
            6:       begin w = 8'd16;  h = 8'd12;  end
            7:       begin w = 8'd5;   h = 8'd3;   end
            8:       begin w = 8'd128; h = 8'd2;   end
            9:       begin w = 8'd2;   h = 8'd1;   end
            10:      begin w = 8'd6;   h = 8'd5;   end
            default: begin w = 8'd4;   h = 8'd4;   end
        endcase
    endfunction

    // mostly white or black so that transitions and blobs show up
    function automatic logic [7:0] random_grey();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return GREY_WHITE;
            4, 5, 6:    return GREY_BLACK;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one item on the input channel; bursts with random gaps in between
    task automatic push_item(input logic [1:0] f, input logic [6:0] x,
                             input logic [6:0] y, input logic [7:0] v);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_x     <= x;
        in_y     <= y;
        in_value <= v;
        // hold the item until the block takes it
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        if (f != FN_UNUSED) items_sent++;
        if (f == FN_START) starts_sent++;
        if (f == FN_NEXT) steps_sent++;
    endtask

    task automatic put_pixel(input int x, input int y, input logic [7:0] v);
        written[y][x] = 1'b1;
        push_item(FN_WRITE, x[6:0], y[6:0], v);
    endtask

    // start, next or the unused code; pixel fields are don't-care, keep them moving
    task automatic push_probe(input logic [1:0] f);
        push_item(f, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)));
    endtask

    // stop offering items and wait until every result is back and the block is idle
    task automatic wait_for_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [7:0] w, input logic [7:0] h);
        wait_for_quiet();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cur_w = used_size(w);
        cur_h = used_size(h);
    endtask

    // new size: define every pixel the scan or a step can reach, then keep
    // stepping a trace that may have started on the old size
    task automatic resize(input logic [7:0] w, input logic [7:0] h);
        set_size(w, h);
        for (int y = 0; y < cur_h; y++) begin
            for (int x = 0; x < cur_w; x++) begin
                if (!written[y][x]) put_pixel(x, y, random_grey());
            end
        end
        repeat ($urandom_range(1, 3)) push_probe(FN_NEXT);
    endtask

    // black rectangle inside a white ring, wrapped around the image edges
    task automatic draw_shape();
        int rw, rh, ox, oy;
        rw = $urandom_range(1, (cur_w < 4) ? cur_w : 4);
        rh = $urandom_range(1, (cur_h < 4) ? cur_h : 4);
        ox = $urandom_range(0, cur_w - 1);
        oy = $urandom_range(0, cur_h - 1);
        for (int dy = -1; dy <= rh; dy++) begin
            for (int dx = -1; dx <= rw; dx++) begin
                if (dy < 0 || dy == rh || dx < 0 || dx == rw) begin
                    put_pixel((ox + dx + cur_w) % cur_w, (oy + dy + cur_h) % cur_h,
                              GREY_WHITE);
                end
            end
        end
        for (int dy = 0; dy < rh; dy++) begin
            for (int dx = 0; dx < rw; dx++) begin
                put_pixel((ox + dx) % cur_w, (oy + dy) % cur_h, GREY_BLACK);
            end
        end
    endtask

    // edit the image a little, start a trace and walk it
    task automatic run_episode();
        case ($urandom_range(0, 7))
            0, 1, 2: draw_shape();
            3, 4, 5: begin
                repeat ($urandom_range(1, 4)) begin
                    put_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                              random_grey());
                end
            end
            6: ;
            default: begin
                // noise: ignored code or a write anywhere in the store
                if ($urandom_range(0, 1) == 0) begin
                    push_probe(FN_UNUSED);
                end else begin
                    put_pixel($urandom_range(0, 127), $urandom_range(0, 127),
                              8'($urandom_range(0, 255)));
                end
            end
        endcase
        if ($urandom_range(0, 5) != 0) push_probe(FN_START);
        repeat ($urandom_range(1, 20)) begin
            // now and then the image changes under a running trace
            if ($urandom_range(0, 15) == 0) begin
                put_pixel($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1),
                          random_grey());
            end
            push_probe(FN_NEXT);
        end
    endtask

    // receiver: stall pattern of its own, changing mode after each random run
    initial begin
        int mode;
        int run;
        mode = 0;
        run = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // long hold-off while the sender keeps offering items
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                if (run == 0) begin
                    mode = $urandom_range(0, 3);
                    run = $urandom_range(20, 120);
                end
                run--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // main stimulus
    initial begin
        int         budget_end;
        logic [7:0] rw, rh;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_func     = FN_WRITE;
        in_x        = '0;
        in_y        = '0;
        in_value    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        hold_req    = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        starts_sent = 0;
        steps_sent  = 0;
        cur_w       = used_size(CFG_RESET_SIZE);
        cur_h       = used_size(CFG_RESET_SIZE);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: step with no trace, ignored code, corner writes at reset size
        push_probe(FN_NEXT);
        push_probe(FN_UNUSED);
        put_pixel(127, 127, GREY_WHITE);
        put_pixel(0, 0, GREY_BLACK);

        // directed on a 4x2 image
        set_size(8'd4, 8'd2);
        for (int i = 0; i < 8; i++) begin
            put_pixel(i % 4, i / 4, 8'(1 + 36 * i));
        end
        push_probe(FN_START);              // nothing white, no transition
        push_probe(FN_NEXT);               // trace inactive
        put_pixel(0, 0, GREY_WHITE);
        put_pixel(1, 0, GREY_BLACK);
        push_probe(FN_START);              // lone black pixel found
        push_probe(FN_NEXT);               // no black neighbour, trace ends
        put_pixel(2, 0, GREY_BLACK);
        push_probe(FN_START);
        push_probe(FN_NEXT);               // moves east
        push_probe(FN_NEXT);               // back onto the start, last point

        // random part, one image size per phase
        for (int phase = 0; phase < PHASES; phase++) begin
            plan_size(phase, rw, rh);
            resize(rw, rh);
            if (phase == 0) hold_req = 1'b1;
            budget_end = items_sent + (ITEM_TARGET - items_sent) / (PHASES - phase);
            run_episode();
            while (items_sent < budget_end) run_episode();
            // leave a fresh trace running into the next size
            draw_shape();
            push_probe(FN_START);
            push_probe(FN_NEXT);
        end

        wait_for_quiet();
        $display("tb: %0d items, %0d starts and %0d steps over %0d image sizes",
                 items_sent, starts_sent, steps_sent, PHASES + 2);
        $display("tb: sizes 1..128 per side incl. zero and saturating register values");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== binary_contour_tracer.f =====
rtl/bct_pkg.sv
rtl/bct_pixel_mem.sv
rtl/bct_step.sv
rtl/bct_ctrl.sv
rtl/binary_contour_tracer.sv
rtl/bct_checker.sv
dv/bct_checker.sv
dv/tb.sv
